// ----- rtl/spap_pkg.sv -----
// Shared types and constants for the sweep-and-prune pair generator.
// Used by spap_walk, spap_key and sweep_prune_axis_pairs; no dependencies.
package spap_pkg;

    localparam int ID_W        = 16;
    localparam int COORD_W     = 16;
    localparam int EXT_W       = 15;
    localparam int EDGE_W      = 17;
    localparam int SUM_W       = 17;
    localparam int KEY_W       = 33;
    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [EDGE_W-1:0] far_edge;
    } entry_t;

    typedef struct packed {
        logic [ID_W-1:0] older_id;
        logic [ID_W-1:0] newer_id;
        logic            last;
        logic            overflow;
    } pair_t;

endpackage

// ----- rtl/spap_walk.sv -----
// Active list memory and its controller: walk and compact, append, then replay
// the surviving entries as candidate pairs. Depends on spap_pkg.
module spap_walk #(
    parameter int MAX_ACTIVE = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [spap_pkg::ID_W-1:0]            in_id,
    input  logic signed [spap_pkg::COORD_W-1:0]  in_lead,
    input  logic signed [spap_pkg::EDGE_W-1:0]   in_far,
    input  logic                                 in_first,
    output logic                                 pair_valid,
    input  logic                                 pair_ready,
    output spap_pkg::pair_t                      pair
);

    localparam int CW  = $clog2(MAX_ACTIVE + 1);
    localparam int AW  = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
    localparam int LIM = (MAX_ACTIVE < spap_pkg::MAX_RESULTS) ? MAX_ACTIVE
                                                              : spap_pkg::MAX_RESULTS;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_WALK     = 4'b0010,
        ST_EMIT_RD  = 4'b0100,
        ST_EMIT_OUT = 4'b1000
    } state_t;

    spap_pkg::entry_t mem [MAX_ACTIVE];
    spap_pkg::entry_t rdata_reg;
    spap_pkg::entry_t wdata;
    logic             mem_we, ren;
    logic [AW-1:0]    waddr, raddr;

    state_t  state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] j_reg, j_next, j_inc;
    logic          chk_valid_reg, chk_valid_next;
    logic          ovf_reg, ovf_next;

    logic [spap_pkg::ID_W-1:0]           id_reg;
    logic signed [spap_pkg::COORD_W-1:0] lead_reg;
    logic signed [spap_pkg::EDGE_W-1:0]  far_reg;
    logic signed [spap_pkg::EDGE_W-1:0]  lead_ext;
    logic                                survive, is_last;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        if (ren) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign lead_ext = {lead_reg[spap_pkg::COORD_W-1], lead_reg};
    assign survive  = lead_ext < rdata_reg.far_edge;
    assign j_inc    = j_reg + CW'(1);
    assign is_last  = (j_inc == n_reg);

    assign pair.older_id = rdata_reg.id;
    assign pair.newer_id = id_reg;
    assign pair.last     = is_last;
    assign pair.overflow = ovf_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        chk_valid_next = 1'b0;
        ovf_next       = ovf_reg;
        mem_we         = 1'b0;
        waddr          = wr_reg[AW-1:0];
        wdata          = rdata_reg;
        ren            = 1'b0;
        raddr          = rd_reg[AW-1:0];
        in_ready       = 1'b0;
        pair_valid     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cnt_next   = in_first ? '0 : cnt_reg;
                    rd_next    = '0;
                    wr_next    = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                // compact survivors in place; write slot always trails read slot
                if (chk_valid_reg && survive) begin
                    mem_we  = 1'b1;
                    wr_next = wr_reg + CW'(1);
                end
                if (rd_reg != cnt_reg) begin
                    ren            = 1'b1;
                    rd_next        = rd_reg + CW'(1);
                    chk_valid_next = 1'b1;
                end else if (!chk_valid_reg) begin
                    if (wr_reg == CW'(MAX_ACTIVE)) begin
                        ovf_next = 1'b1;
                        cnt_next = wr_reg;
                    end else begin
                        mem_we         = 1'b1;
                        wdata.id       = id_reg;
                        wdata.far_edge = far_reg;
                        cnt_next       = wr_reg + CW'(1);
                    end
                    n_next     = (wr_reg > CW'(LIM)) ? CW'(LIM) : wr_reg;
                    state_next = (wr_reg == '0) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                ren        = 1'b1;
                raddr      = '0;
                j_next     = '0;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                pair_valid = 1'b1;
                if (pair_ready) begin
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        ren    = 1'b1;
                        raddr  = j_inc[AW-1:0];
                        j_next = j_inc;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            chk_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            chk_valid_reg <= chk_valid_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            id_reg   <= in_id;
            lead_reg <= in_lead;
            far_reg  <= in_far;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_ACTIVE))
        else $error("active count above list depth");

    a_wr_trails_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_reg <= rd_reg)
        else $error("compaction write overtook read");

    a_no_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && ren) |-> (waddr != raddr))
        else $error("read and write hit the same entry");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_pair_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_valid |-> (n_reg != '0) && (j_reg < n_reg))
        else $error("pair index outside reported range");
`endif

endmodule

// ----- rtl/spap_key.sv -----
// Pair key pipeline: Cantor key multiply stage and output register with stall.
// Depends on spap_pkg.
module spap_key (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  spap_pkg::pair_t                in_pair,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [spap_pkg::ID_W-1:0]      m_older_id,
    output logic [spap_pkg::ID_W-1:0]      m_newer_id,
    output logic [spap_pkg::KEY_W-1:0]     m_pair_key,
    output logic                           m_last_in_run,
    output logic                           m_overflow_seen
);

    localparam int PROD_W = 2 * spap_pkg::SUM_W + 1;

    logic                          s1_valid_reg, s1_valid_next;
    spap_pkg::pair_t               s1_pair_reg;
    logic [PROD_W-1:0]             s1_prod_reg;
    logic [spap_pkg::SUM_W-1:0]    sum;
    logic [spap_pkg::SUM_W:0]      sum_inc;
    logic [PROD_W-1:0]             prod;
    logic                          out_load, s1_adv, in_take;

    logic                          m_valid_reg;
    spap_pkg::pair_t               m_pair_reg;
    logic [spap_pkg::KEY_W-1:0]    m_key_reg, key_next;

    assign sum      = {1'b0, in_pair.older_id} + {1'b0, in_pair.newer_id};
    assign sum_inc  = {1'b0, sum} + (spap_pkg::SUM_W + 1)'(1);
    assign prod     = PROD_W'(sum) * PROD_W'(sum_inc);
    assign key_next = spap_pkg::KEY_W'(s1_prod_reg >> 1)
                    + spap_pkg::KEY_W'(s1_pair_reg.newer_id);

    assign out_load = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_load;
    assign in_ready = !s1_valid_reg || out_load;
    assign in_take  = in_valid && in_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_take) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (out_load) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            s1_pair_reg <= in_pair;
            s1_prod_reg <= prod;
        end
        if (s1_adv) begin
            m_pair_reg <= s1_pair_reg;
            m_key_reg  <= key_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_older_id      = m_pair_reg.older_id;
    assign m_newer_id      = m_pair_reg.newer_id;
    assign m_pair_key      = m_key_reg;
    assign m_last_in_run   = m_pair_reg.last;
    assign m_overflow_seen = m_pair_reg.overflow;

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_pair_key))
        else $error("output changed while stalled");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_load) |=> s1_valid_reg && $stable(s1_prod_reg))
        else $error("multiply stage lost its item");

    a_no_take_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |-> !in_ready)
        else $error("pipeline took an item while full");
`endif

endmodule

// ----- rtl/sweep_prune_axis_pairs.sv -----
// Sweep-and-prune broadphase on one axis: boxes arrive sorted by leading edge; each
// box is checked against an active list and produces one transfer per overlapping pair,
// up to MAX_RESULTS per box; a first box starts with an empty list. Each box is handled
// by walking the list memory once to compact it and once more to replay the survivors,
// and a new box is taken only when the last one is through. Pairs leave at one per cycle
// when not stalled; the key pipeline registers each pair in a multiply stage and an
// output register. axis_reg is written through cfg_*.
// Depends on spap_pkg, spap_walk and spap_key.
module sweep_prune_axis_pairs #(
    parameter int MAX_ACTIVE = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [spap_pkg::ID_W-1:0]            s_box_id,
    input  logic signed [spap_pkg::COORD_W-1:0]  s_x_left,
    input  logic signed [spap_pkg::COORD_W-1:0]  s_y_top,
    input  logic [spap_pkg::EXT_W-1:0]           s_width,
    input  logic [spap_pkg::EXT_W-1:0]           s_height,
    input  logic                                 s_first_box,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [spap_pkg::ID_W-1:0]            m_older_id,
    output logic [spap_pkg::ID_W-1:0]            m_newer_id,
    output logic [spap_pkg::KEY_W-1:0]           m_pair_key,
    output logic                                 m_last_in_run,
    output logic                                 m_overflow_seen
);

    logic                                axis_reg;
    logic signed [spap_pkg::COORD_W-1:0] lead;
    logic [spap_pkg::EXT_W-1:0]          ext;
    logic signed [spap_pkg::EDGE_W-1:0]  far_edge;
    logic                                pair_valid, pair_ready;
    spap_pkg::pair_t                     pair;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            axis_reg <= cfg_data;
        end
    end

    assign lead     = axis_reg ? s_y_top : s_x_left;
    assign ext      = axis_reg ? s_height : s_width;
    assign far_edge = {lead[spap_pkg::COORD_W-1], lead} + {2'b00, ext};

    spap_walk #(
        .MAX_ACTIVE (MAX_ACTIVE)
    ) u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_id      (s_box_id),
        .in_lead    (lead),
        .in_far     (far_edge),
        .in_first   (s_first_box),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair)
    );

    spap_key u_key (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (pair_valid),
        .in_ready        (pair_ready),
        .in_pair         (pair),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_older_id      (m_older_id),
        .m_newer_id      (m_newer_id),
        .m_pair_key      (m_pair_key),
        .m_last_in_run   (m_last_in_run),
        .m_overflow_seen (m_overflow_seen)
    );

`ifndef NO_ASSERTIONS
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_in_run) |-> !s_ready || !(pair_valid == 1'b0
            && $past(s_ready) && s_ready && !u_key.s1_valid_reg))
        else $error("run ended without a last pair");

    a_ovf_out_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_overflow_seen) |=> !m_valid || m_overflow_seen)
        else $error("overflow flag dropped between pairs");

    a_newer_stable_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_in_run) |=> !m_valid
            || (m_newer_id == $past(m_newer_id)))
        else $error("newer id changed inside a run");
`endif

endmodule
